/* design/mrg_pkg.sv */
// Shared constants, register indexes and payload types for the motor run guard.
`default_nettype none

package mrg_pkg;

	// Field widths
	localparam int DUTY_BITS      = 16;
	localparam int CURRENT_BITS   = 12;
	localparam int TIMER_BITS     = 16;
	localparam int COUNT_BITS     = 10;
	localparam int TIMEOUT_BITS   = 16;
	localparam int OC_THR_BITS    = 12;
	localparam int OC_MAX_BITS    = 10;
	localparam int FWD_LIMIT_BITS = 16;
	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 16;

	// 1/1.07 in Q15, rounded
	localparam int RECIP_BITS = 15;
	localparam logic [RECIP_BITS-1:0] RECIP_107 = RECIP_BITS'(30624);

	// Working widths
	localparam int TMO_CMP_BITS = (TIMER_BITS > TIMEOUT_BITS) ? TIMER_BITS : TIMEOUT_BITS;
	localparam int LIM_BITS =
		((DUTY_BITS > FWD_LIMIT_BITS) ? DUTY_BITS : FWD_LIMIT_BITS) + 3;
	localparam int PROD_BITS = DUTY_BITS + RECIP_BITS + 1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

	// Register reset values
	localparam logic [TIMEOUT_BITS-1:0]   RST_RUN_TIMEOUT = TIMEOUT_BITS'(250);
	localparam logic [OC_THR_BITS-1:0]    RST_OC_THRESH   = OC_THR_BITS'(1280);
	localparam logic [OC_MAX_BITS-1:0]    RST_OC_MAX      = OC_MAX_BITS'(150);
	localparam logic [FWD_LIMIT_BITS-1:0] RST_FWD_LIMIT   = FWD_LIMIT_BITS'(32768);

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_RUN_TIMEOUT = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_OC_THRESH   = CFG_INDEX_BITS'(1);
	localparam logic [CFG_INDEX_BITS-1:0] REG_OC_MAX      = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] REG_FWD_LIMIT   = CFG_INDEX_BITS'(3);

	typedef struct packed {
		logic                           enabled;
		logic signed [DUTY_BITS-1:0]    requested_duty;
		logic        [CURRENT_BITS-1:0] motor_current;
		logic signed [DUTY_BITS-1:0]    forward_speed;
	} in_item_t;

	typedef struct packed {
		logic signed [DUTY_BITS-1:0]    drive_duty;
		logic                           tripped;
		logic        [CURRENT_BITS-1:0] reported_current;
	} out_item_t;

	typedef struct packed {
		logic [TIMEOUT_BITS-1:0]   run_timeout_ticks;
		logic [OC_THR_BITS-1:0]    overcurrent_threshold;
		logic [OC_MAX_BITS-1:0]    overcurrent_max_count;
		logic [FWD_LIMIT_BITS-1:0] forward_limit;
	} cfg_t;

	// Guard verdict handed to the datapath
	typedef struct packed {
		logic                        tripped;
		logic signed [DUTY_BITS-1:0] duty;
	} guard_res_t;

endpackage

`default_nettype wire

/* design/mrg_ifs.sv */
// Valid/ready channel interfaces for items, results and register writes.
`default_nettype none

interface mrg_in_if;
	logic               valid;
	logic               ready;
	mrg_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mrg_out_if;
	logic               valid;
	logic               ready;
	mrg_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mrg_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [mrg_pkg::CFG_INDEX_BITS-1:0]   index;
	logic [mrg_pkg::CFG_DATA_BITS-1:0]    wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

/* design/mrg_cfg_regs.sv */
// Configuration register file.
`default_nettype none

module mrg_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr,
	input  wire logic [mrg_pkg::CFG_INDEX_BITS-1:0]  index,
	input  wire logic [mrg_pkg::CFG_DATA_BITS-1:0]   wdata,
	output mrg_pkg::cfg_t                            cfg
);

	mrg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_timeout_ticks     <= mrg_pkg::RST_RUN_TIMEOUT;
			cfg_q.overcurrent_threshold <= mrg_pkg::RST_OC_THRESH;
			cfg_q.overcurrent_max_count <= mrg_pkg::RST_OC_MAX;
			cfg_q.forward_limit         <= mrg_pkg::RST_FWD_LIMIT;
		end else if (wr) begin
			case (index)
				mrg_pkg::REG_RUN_TIMEOUT: begin
					cfg_q.run_timeout_ticks <= mrg_pkg::TIMEOUT_BITS'(wdata);
				end
				mrg_pkg::REG_OC_THRESH: begin
					cfg_q.overcurrent_threshold <= mrg_pkg::OC_THR_BITS'(wdata);
				end
				mrg_pkg::REG_OC_MAX: begin
					cfg_q.overcurrent_max_count <= mrg_pkg::OC_MAX_BITS'(wdata);
				end
				mrg_pkg::REG_FWD_LIMIT: begin
					cfg_q.forward_limit <= mrg_pkg::FWD_LIMIT_BITS'(wdata);
				end
				default: begin
					// unknown index: dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* design/mrg_guard.sv */
// Run stopwatch, overcurrent counter and trip flag.
`default_nettype none

module mrg_guard (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire mrg_pkg::in_item_t item,
	input  wire mrg_pkg::cfg_t     cfg,
	output mrg_pkg::guard_res_t res
);

	logic                                   run_q, run_d;
	logic [mrg_pkg::TIMER_BITS-1:0]         elapsed_q, elapsed_d;
	logic                                   trip_q, trip_d;
	logic [mrg_pkg::COUNT_BITS-1:0]         count_q, count_d;
	logic signed [mrg_pkg::DUTY_BITS-1:0]   prev_q, prev_d;
	logic                                   req_zero;
	logic                                   over;

	assign req_zero = (item.requested_duty == '0);
	assign over = item.motor_current >=
		mrg_pkg::CURRENT_BITS'(cfg.overcurrent_threshold);

	always_comb begin
		run_d     = run_q;
		elapsed_d = elapsed_q;
		trip_d    = trip_q;
		count_d   = count_q;
		prev_d    = prev_q;
		if (!item.enabled) begin
			trip_d = 1'b0;
		end else begin
			if (req_zero) begin
				run_d     = 1'b0;
				elapsed_d = '0;
				trip_d    = 1'b0;
			end else if (prev_q == '0) begin
				elapsed_d = '0;
				run_d     = 1'b1;
			end
			if (run_d && (elapsed_d != mrg_pkg::TIMER_MAX))
				elapsed_d = elapsed_d + 1'b1;
			if (mrg_pkg::TMO_CMP_BITS'(elapsed_d) >
				mrg_pkg::TMO_CMP_BITS'(cfg.run_timeout_ticks)) begin
				trip_d    = 1'b1;
				run_d     = 1'b0;
				elapsed_d = '0;
			end
			if (over) begin
				if (mrg_pkg::COUNT_BITS'(count_q) >
					mrg_pkg::COUNT_BITS'(cfg.overcurrent_max_count)) begin
					trip_d = 1'b1;
					if (run_d) begin
						run_d     = 1'b0;
						elapsed_d = '0;
					end
				end
				if (count_q != mrg_pkg::COUNT_MAX)
					count_d = count_q + 1'b1;
			end else begin
				count_d = '0;
			end
			prev_d = item.requested_duty;
		end
	end

	assign res.tripped = trip_d;
	assign res.duty    = trip_d ? '0 : item.requested_duty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			elapsed_q <= '0;
			trip_q    <= 1'b0;
			count_q   <= '0;
			prev_q    <= '0;
		end else if (step) begin
			run_q     <= run_d;
			elapsed_q <= elapsed_d;
			trip_q    <= trip_d;
			count_q   <= count_d;
			prev_q    <= prev_d;
		end
	end

	// stopped watch always holds a cleared count
	a_idle_watch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> elapsed_q == '0)
		else $error("stopwatch stopped with nonzero count");

	// disabled period only drops the trip flag
	a_disabled_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.enabled |=>
		count_q == $past(count_q) && prev_q == $past(prev_q) &&
		run_q == $past(run_q) && !trip_q)
		else $error("disabled period changed guard state");

	// zero request below the overcurrent threshold clears the trip
	a_zero_req_untrips: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.enabled && req_zero && !over |=> !trip_q && !run_q)
		else $error("zero request left guard tripped or running");

endmodule

`default_nettype wire

/* design/mrg_limiter.sv */
// Accelerating duty cap against scaled speed, with output saturation.
`default_nettype none

module mrg_limiter (
	input  wire logic signed [mrg_pkg::DUTY_BITS-1:0]   duty,
	input  wire logic signed [mrg_pkg::DUTY_BITS-1:0]   speed,
	input  wire logic        [mrg_pkg::FWD_LIMIT_BITS-1:0] fwd_limit,
	output logic signed      [mrg_pkg::DUTY_BITS-1:0]   drive
);

	localparam logic signed [mrg_pkg::LIM_BITS-1:0] DMAX =
		mrg_pkg::LIM_BITS'((2 ** (mrg_pkg::DUTY_BITS - 1)) - 1);
	localparam logic [mrg_pkg::PROD_BITS-1:0] ROUND_HALF =
		mrg_pkg::PROD_BITS'(2 ** (mrg_pkg::RECIP_BITS - 1));

	logic                                  neg;
	logic        [mrg_pkg::DUTY_BITS-1:0]  mag;
	logic        [mrg_pkg::PROD_BITS-1:0]  prod;
	logic signed [mrg_pkg::LIM_BITS-1:0]   d_m, scaled, cap, d_lim, d_out;

	always_comb begin
		neg  = speed[mrg_pkg::DUTY_BITS-1];
		// mirror negative speed so the cap is always on the positive side
		d_m  = neg ? -mrg_pkg::LIM_BITS'(duty) : mrg_pkg::LIM_BITS'(duty);
		mag  = neg ? $unsigned(~speed + 1'b1) : $unsigned(speed);
		prod = mrg_pkg::PROD_BITS'(mag) * mrg_pkg::PROD_BITS'(mrg_pkg::RECIP_107) +
			ROUND_HALF;
		scaled = $signed(mrg_pkg::LIM_BITS'(prod >> mrg_pkg::RECIP_BITS));
		cap    = scaled + $signed(mrg_pkg::LIM_BITS'(fwd_limit));
		d_lim  = d_m;
		if ((d_m > scaled) && (d_m > cap))
			d_lim = cap;
		d_out = neg ? -d_lim : d_lim;
		if (d_out > DMAX)
			d_out = DMAX;
		else if (d_out < -DMAX)
			d_out = -DMAX;
		drive = mrg_pkg::DUTY_BITS'(d_out);
	end

endmodule

`default_nettype wire

/* design/motor_run_guard_with_current_limit.sv */
// Top level of the motor run guard: input stage, guard, limiter and result register.
// Pipeline: a transaction accepted into the input stage is processed as it moves into
//   the result register and is shown on out from then on (two register stages).
// Throughput: one transaction per cycle while out takes results; guard state updates per transaction.
// Reset: arst_n clears guard state and handshake flags, loads register defaults.
// Configuration writes are taken in every cycle (cfg.ready is tied high).
`default_nettype none

module motor_run_guard_with_current_limit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mrg_in_if.sink      in,
	mrg_out_if.source   out,
	mrg_cfg_if.sink     cfg
);

	// Input stage
	logic                 valid_s1;
	mrg_pkg::in_item_t    item_s1;
	// Result register
	logic                 out_valid_q;
	mrg_pkg::out_item_t   out_q;

	mrg_pkg::cfg_t        cfg_regs;
	mrg_pkg::guard_res_t  guard_res;
	logic signed [mrg_pkg::DUTY_BITS-1:0] limited;
	logic                 advance;
	logic                 in_take;

	// Stage 1 moves into the result register whenever that register is free
	// or being drained this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out.ready);
	assign in.ready = !valid_s1 || advance;
	assign in_take  = in.valid && in.ready;

	assign cfg.ready = 1'b1;

	mrg_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg.valid),
		.index  (cfg.index),
		.wdata  (cfg.wdata),
		.cfg    (cfg_regs)
	);

	// Stopwatch / overcurrent state advances once per processed transaction
	mrg_guard u_guard (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_regs),
		.res    (guard_res)
	);

	// Duty cap on the already trip-gated request
	mrg_limiter u_limiter (
		.duty      (guard_res.duty),
		.speed     (item_s1.forward_speed),
		.fwd_limit (cfg_regs.forward_limit),
		.drive     (limited)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Disabled period: zero drive, no trip, zero reported current
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.drive_duty       <= item_s1.enabled ? limited : '0;
			out_q.tripped          <= item_s1.enabled && guard_res.tripped;
			out_q.reported_current <= item_s1.enabled ? item_s1.motor_current : '0;
		end
	end

	assign out.valid = out_valid_q;
	assign out.data  = out_q;

	// a tripped result never drives the motor
	a_trip_zero_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.tripped |-> out_q.drive_duty == '0)
		else $error("tripped result with nonzero drive");

	// a stalled input stage keeps its transaction
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a stalled transaction");

	// every processed transaction lands in the result register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed transaction did not reach result register");

endmodule

`default_nettype wire
